>>> hw/rtl/frnp_pkg.sv
`default_nettype none
package frnp_pkg;

  // default format: binary64
  localparam int FRAC_BITS_DEF = 52;
  localparam int EXP_WIDTH_DEF = 11;
  localparam int EXP_BIAS_DEF  = 1023;

  // fixed port widths
  localparam int MANT_W   = 64;
  localparam int EXP_IN_W = 16;
  localparam int RESULT_W = 64;

  // internal signed exponent, wide enough for input range plus all adjustments
  localparam int EXP_INT_W = 18;

  // width of a bit length of the mantissa (0..64)
  localparam int BLEN_W = $clog2(MANT_W + 1);

  // register stages from accepted start to done
  localparam int LATENCY = 6;

endpackage
`default_nettype wire

>>> hw/rtl/float_round_normalize_pack_top.sv
// Channel   Handshake          Payload                       Notes
// input     start / busy       sign, mantissa, exponent      beat taken when start && !busy
// result    done (strobe)      result_bits                   valid for exactly one cycle
//
// One beat per cycle sustained; busy is never raised.
// A beat passes through six register stages (input, bit length, narrow/normalize
// shift, round, denormal shift, pack); done and result_bits are registered together
// in the pack stage.
// rst (synchronous) clears the stage valid bits only; beats in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module float_round_normalize_pack_top #(
  parameter int FRAC_BITS = frnp_pkg::FRAC_BITS_DEF,
  parameter int EXP_WIDTH = frnp_pkg::EXP_WIDTH_DEF,
  parameter int EXP_BIAS  = frnp_pkg::EXP_BIAS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                sign,
  input  wire logic [frnp_pkg::MANT_W-1:0]         mantissa,
  input  wire logic signed [frnp_pkg::EXP_IN_W-1:0] exponent,
  output logic [frnp_pkg::RESULT_W-1:0]            result_bits,
  output logic                                     done
);
  import frnp_pkg::*;

  localparam int MW = FRAC_BITS + 1;
  localparam logic signed [EXP_INT_W-1:0] BIAS_ADJ =
    EXP_INT_W'(FRAC_BITS - 1 + EXP_BIAS);
  localparam logic signed [EXP_INT_W-1:0] EXP_ONES =
    EXP_INT_W'((1 << EXP_WIDTH) - 1);

  function automatic logic [BLEN_W-1:0] bit_len(input logic [MANT_W-1:0] v);
    logic [MANT_W-1:0] w;
    logic [BLEN_W-2:0] msb;
    w   = v;
    msb = '0;
    for (int k = BLEN_W - 2; k >= 0; k--) begin
      if ((w >> (1 << k)) != '0) begin
        msb[k] = 1'b1;
        w      = w >> (1 << k);
      end
    end
    bit_len = (v == '0) ? '0 : BLEN_W'(msb) + BLEN_W'(1);
  endfunction

  assign busy = 1'b0;

  // stage 0: input register
  logic                         v0;
  logic                         s0_sign;
  logic [MANT_W-1:0]            s0_m;
  logic signed [EXP_INT_W-1:0]  s0_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    s0_sign <= sign;
    s0_m    <= mantissa;
    s0_e    <= EXP_INT_W'(exponent);
  end

  // stage 1: bit length
  logic                         v1;
  logic                         s1_sign;
  logic [MANT_W-1:0]            s1_m;
  logic signed [EXP_INT_W-1:0]  s1_e;
  logic [BLEN_W-1:0]            s1_bl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    s1_sign <= s0_sign;
    s1_m    <= s0_m;
    s1_e    <= s0_e;
    s1_bl   <= bit_len(s0_m);
  end

  // stage 2: narrow an over-wide mantissa, or normalize left
  logic                         wide;
  logic [BLEN_W-1:0]            rsh;
  logic [BLEN_W-1:0]            lsh;
  logic [MANT_W:0]              rsh_full;
  logic [MANT_W-1:0]            lsh_full;
  logic [MW-1:0]                s2_m_next;
  logic                         s2_last_next;
  logic signed [EXP_INT_W-1:0]  s2_e_next;

  always_comb begin
    wide     = s1_bl > BLEN_W'(MW);
    rsh      = s1_bl - BLEN_W'(MW);
    lsh      = (s1_bl == '0) ? '0 : BLEN_W'(MW) - s1_bl;
    // extra low bit catches the last bit shifted out
    rsh_full = {s1_m, 1'b0} >> rsh;
    lsh_full = s1_m << lsh;
    if (wide) begin
      s2_m_next    = rsh_full[MW:1];
      s2_last_next = rsh_full[0];
      s2_e_next    = s1_e + EXP_INT_W'(rsh);
    end else begin
      s2_m_next    = lsh_full[MW-1:0];
      s2_last_next = 1'b0;
      s2_e_next    = s1_e - EXP_INT_W'(lsh);
    end
  end

  logic                         v2;
  logic                         s2_sign;
  logic [MW-1:0]                s2_m;
  logic                         s2_last;
  logic signed [EXP_INT_W-1:0]  s2_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_sign <= s1_sign;
    s2_m    <= s2_m_next;
    s2_last <= s2_last_next;
    s2_e    <= s2_e_next;
  end

  // stage 3: add back the last bit, fix a carry to the next power, bias
  logic [MW:0]                  rsum;
  logic [MW-1:0]                s3_m_next;
  logic signed [EXP_INT_W-1:0]  s3_bexp_next;

  always_comb begin
    rsum         = {1'b0, s2_m} + (MW + 1)'(s2_last);
    s3_m_next    = rsum[MW] ? rsum[MW:1] : rsum[MW-1:0];
    s3_bexp_next = s2_e + BIAS_ADJ + EXP_INT_W'(rsum[MW]);
  end

  logic                         v3;
  logic                         s3_sign;
  logic [MW-1:0]                s3_m;
  logic signed [EXP_INT_W-1:0]  s3_bexp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_sign <= s2_sign;
    s3_m    <= s3_m_next;
    s3_bexp <= s3_bexp_next;
  end

  // stage 4: denormal shift and range classification
  logic [EXP_INT_W-1:0]         dsh;
  logic [MW-1:0]                s4_m_next;

  always_comb begin
    dsh = -s3_bexp;
    if (s3_bexp < 0) begin
      s4_m_next = (dsh >= EXP_INT_W'(MANT_W)) ? '0 : s3_m >> dsh[BLEN_W-2:0];
    end else begin
      s4_m_next = s3_m;
    end
  end

  logic                         v4;
  logic                         s4_sign;
  logic [MW-1:0]                s4_m;
  logic                         s4_den;
  logic                         s4_inf;
  logic [EXP_WIDTH-1:0]         s4_efield;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_sign   <= s3_sign;
    s4_m      <= s4_m_next;
    s4_den    <= s3_bexp < EXP_INT_W'(1);
    s4_inf    <= s3_bexp >= EXP_ONES;
    s4_efield <= s3_bexp[EXP_WIDTH-1:0];
  end

  // stage 5: denormal rounding and pack
  logic [MW:0]                  dsum;
  logic [RESULT_W-1:0]          word;

  always_comb begin
    dsum = {1'b0, s4_m} + (MW + 1)'(1);
    word = '0;
    word[FRAC_BITS+EXP_WIDTH] = s4_sign;
    priority if (s4_inf) begin
      word[FRAC_BITS+EXP_WIDTH-1:FRAC_BITS] = '1;
    end else if (s4_den) begin
      // round half up; a carry lands in the exponent field's low bit
      word[FRAC_BITS:0] = dsum[MW:1];
    end else begin
      word[FRAC_BITS+EXP_WIDTH-1:FRAC_BITS] = s4_efield;
      word[FRAC_BITS-1:0] = s4_m[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    result_bits <= word;
  end

endmodule
`default_nettype wire

>>> hw/rtl/frnp_checker.sv
`default_nettype none
module frnp_checker #(
  parameter int FRAC_BITS = frnp_pkg::FRAC_BITS_DEF,
  parameter int EXP_WIDTH = frnp_pkg::EXP_WIDTH_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           sign,
  input wire logic [frnp_pkg::RESULT_W-1:0]  result_bits,
  input wire logic                           done
);
  import frnp_pkg::*;

  // every accepted beat comes out after the fixed latency
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat produced no result");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching beat");

  // sign travels unchanged
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY
      (result_bits[FRAC_BITS+EXP_WIDTH] == $past(sign, LATENCY)))
    else $error("result sign mismatch");

  // all-ones exponent is always infinity, never NaN
  a_no_nan: assert property (@(posedge clk) disable iff (rst)
    (done && (&result_bits[FRAC_BITS+EXP_WIDTH-1:FRAC_BITS]))
      |-> (result_bits[FRAC_BITS-1:0] == '0))
    else $error("NaN pattern on result");

endmodule

bind float_round_normalize_pack_top frnp_checker #(
  .FRAC_BITS(FRAC_BITS),
  .EXP_WIDTH(EXP_WIDTH)
) u_frnp_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .sign(sign),
  .result_bits(result_bits),
  .done(done)
);
`default_nettype wire
